// File: src/timed_sphere_collision_check_defines.svh
// Assertion macros shared by the timed sphere collision check RTL
`ifndef TIMED_SPHERE_COLLISION_CHECK_DEFINES_SVH
`define TIMED_SPHERE_COLLISION_CHECK_DEFINES_SVH

// condition holds on every clock edge out of reset
`define TSCC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tscc: invariant violated");

// consequent holds in the same cycle as the antecedent
`define TSCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tscc: implication violated");

// consequent holds in the cycle after the antecedent
`define TSCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tscc: sequence violated");

`endif

// File: src/tscc_pkg.sv
// Types and constants shared by the timed sphere collision check blocks
`default_nettype none

package tscc_pkg;

    // number of coordinate fields carried by one item
    localparam int NUM_POS = 4;

    // request codes on the input channel
    localparam logic [2:0] REQ_QUERY  = 3'd0;
    localparam logic [2:0] REQ_WR_WP  = 3'd1;
    localparam logic [2:0] REQ_WR_RAD = 3'd2;
    localparam logic [2:0] REQ_WR_LO  = 3'd3;
    localparam logic [2:0] REQ_WR_HI  = 3'd4;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_AGENT_RADIUS     = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_DIMS      = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_OBSTACLES = 2'd2;

    // register reset values
    localparam logic [30:0] RST_AGENT_RADIUS     = 31'd0;
    localparam logic [2:0]  RST_ACTIVE_DIMS      = 3'd2;
    localparam logic [4:0]  RST_ACTIVE_OBSTACLES = 5'd0;

    typedef enum logic [2:0] {
        OP_QUERY,
        OP_WR_WP,
        OP_WR_RAD,
        OP_WR_LO,
        OP_WR_HI
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [3:0]                 obs;
        logic [2:0]                 pt;
        logic [1:0]                 dim;
        logic [31:0]                value;
        logic [NUM_POS-1:0][31:0]   pos;
        logic [31:0]                time_value;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_BOUND,
        BS_MOD,
        BS_ISSUE,
        BS_DRAIN,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic start;
        logic issue;
    } t_eval_ctl;

    typedef struct packed {
        logic busy;
        logic found;
    } t_eval_st;

    typedef struct packed {
        logic       state_valid;
        logic       out_of_bounds;
        logic       collided;
        logic [3:0] hit_obstacle;
    } t_result;

endpackage

`default_nettype wire

// File: src/tscc_front.sv
// Front end: decodes input items and drops those that have no effect
`default_nettype none

module tscc_front import tscc_pkg::*; #(
    parameter int MAX_DIMS      = 4,
    parameter int MAX_OBSTACLES = 16,
    parameter int PATH_POINTS   = 8
) (
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [2:0]               i_req_type,
    input  logic [3:0]               i_obstacle_index,
    input  logic [2:0]               i_point_index,
    input  logic [1:0]               i_dim_index,
    input  logic [31:0]              i_write_value,
    input  logic [NUM_POS-1:0][31:0] i_pos,
    input  logic [31:0]              i_time_value,
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output t_cmd                     o_cmd
);

    logic w_keep;
    logic w_obs_ok;
    logic w_pt_ok;
    logic w_dim_ok;

    // address range checks
    assign w_obs_ok = 32'(i_obstacle_index) < MAX_OBSTACLES;
    assign w_pt_ok  = 32'(i_point_index) < PATH_POINTS;
    assign w_dim_ok = 32'(i_dim_index) < MAX_DIMS;

    // request decode
    always_comb begin
        o_cmd.op = OP_QUERY;
        w_keep   = 1'b0;
        unique case (i_req_type) inside
            REQ_QUERY: begin
                o_cmd.op = OP_QUERY;
                w_keep   = 1'b1;
            end
            REQ_WR_WP: begin
                o_cmd.op = OP_WR_WP;
                w_keep   = w_obs_ok && w_pt_ok && w_dim_ok;
            end
            REQ_WR_RAD: begin
                o_cmd.op = OP_WR_RAD;
                w_keep   = w_obs_ok;
            end
            REQ_WR_LO, REQ_WR_HI: begin
                o_cmd.op = (i_req_type == REQ_WR_LO) ? OP_WR_LO : OP_WR_HI;
                w_keep   = w_dim_ok;
            end
            default: begin
                o_cmd.op = OP_QUERY;
                w_keep   = 1'b0;
            end
        endcase
    end

    assign o_cmd.obs        = i_obstacle_index;
    assign o_cmd.pt         = i_point_index;
    assign o_cmd.dim        = i_dim_index;
    assign o_cmd.value      = i_write_value;
    assign o_cmd.pos        = i_pos;
    assign o_cmd.time_value = i_time_value;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full && w_keep;

endmodule

`default_nettype wire

// File: src/tscc_fifo.sv
// Short command queue between the front end and the back end
`default_nettype none

module tscc_fifo import tscc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'(DEPTH);
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/tscc_eval.sv
// Obstacle distance pipeline with waypoint and radius memories
`default_nettype none

module tscc_eval import tscc_pkg::*; #(
    parameter int MAX_DIMS      = 4,
    parameter int MAX_OBSTACLES = 16,
    parameter int PATH_POINTS   = 8,
    localparam int LANES = (MAX_DIMS < NUM_POS) ? MAX_DIMS : NUM_POS,
    localparam int OBS_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1,
    localparam int PT_W  = $clog2(PATH_POINTS),
    localparam int ROWS  = MAX_OBSTACLES * PATH_POINTS,
    localparam int ROW_W = $clog2(ROWS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_eval_ctl                i_ctl,
    input  logic [OBS_W-1:0]         i_k,
    input  logic [PT_W-1:0]          i_p1,
    input  logic [PT_W-1:0]          i_p2,
    input  logic [15:0]              i_frac,
    input  logic [NUM_POS-1:0][31:0] i_pos,
    input  logic [2:0]               i_nd,
    input  logic [30:0]              i_agent_r,
    input  logic                     i_wp_we,
    input  logic [ROW_W-1:0]         i_wp_row,
    input  logic [1:0]               i_wp_lane,
    input  logic                     i_rad_we,
    input  logic [OBS_W-1:0]         i_rad_addr,
    input  logic [31:0]              i_wdata,
    output t_eval_st                 o_st,
    output logic [OBS_W-1:0]         o_hit
);

    logic [ROW_W-1:0]  w_row_a;
    logic [ROW_W-1:0]  w_row_b;
    logic [31:0]       r_rmem [MAX_OBSTACLES];
    logic [5:0]        r_vld;
    logic [OBS_W-1:0]  r_k1, r_k2, r_k3, r_k4, r_k5, r_k6;
    logic signed [31:0] r_rad1;
    logic signed [32:0] r_rs2;
    logic [63:0]       r_lim3, r_lim4, r_lim5, r_lim6;
    logic              r_ok3, r_ok4, r_ok5, r_ok6;
    logic [63:0]       r_sq5 [LANES];
    logic [71:0]       w_sum;
    logic [71:0]       r_sum6;
    logic              w_hit;
    logic              r_found;
    logic [OBS_W-1:0]  r_hit;

    // rows of the two waypoints around the query time
    assign w_row_a = ROW_W'(32'(i_k) * PATH_POINTS + 32'(i_p1));
    assign w_row_b = ROW_W'(32'(i_k) * PATH_POINTS + 32'(i_p2));

    // one lane per coordinate: read, interpolate, subtract, square
    for (genvar d = 0; d < LANES; d++) begin : g_lane
        logic [31:0]        r_mem [ROWS];
        logic signed [31:0] r_a1, r_b1, r_a2, r_a3;
        logic signed [32:0] r_diff2;
        logic signed [49:0] r_prod3;
        logic [31:0]        r_m4;
        logic signed [33:0] w_c;
        logic signed [35:0] w_df;
        logic [31:0]        w_m;

        always_ff @(posedge i_clk) begin
            if (i_wp_we && (32'(i_wp_lane) == d)) begin
                r_mem[i_wp_row] <= i_wdata;
            end
            r_a1    <= $signed(r_mem[w_row_a]);
            r_b1    <= $signed(r_mem[w_row_b]);
            r_diff2 <= 33'(r_b1) - 33'(r_a1);
            r_a2    <= r_a1;
            r_prod3 <= $signed({1'b0, i_frac}) * r_diff2;
            r_a3    <= r_a2;
            r_m4    <= w_m;
            r_sq5[d] <= 64'(r_m4) * 64'(r_m4);
        end

        // interpolated position, rounded down, and distance magnitude
        // (both ends lie in the 32-bit signed range, so the magnitude fits 32 bits)
        always_comb begin
            w_c  = 34'(r_a3) + 34'(r_prod3 >>> 16);
            w_df = 36'($signed(i_pos[d])) - 36'(w_c);
            w_m  = w_df[35] ? 32'(-w_df) : 32'(w_df);
            if (3'(d) >= i_nd) begin
                w_m = '0;
            end
        end
    end

    // radius memory and limit path
    always_ff @(posedge i_clk) begin
        if (i_rad_we) begin
            r_rmem[i_rad_addr] <= i_wdata;
        end
        r_rad1 <= $signed(r_rmem[i_k]);
        r_rs2  <= 33'($signed({2'b00, i_agent_r})) + 33'(r_rad1);
        r_lim3 <= 64'(r_rs2[31:0]) * 64'(r_rs2[31:0]);
        r_ok3  <= !r_rs2[32] && (r_rs2 != '0);
        r_lim4 <= r_lim3;
        r_ok4  <= r_ok3;
        r_lim5 <= r_lim4;
        r_ok5  <= r_ok4;
        r_lim6 <= r_lim5;
        r_ok6  <= r_ok5;
        r_sum6 <= w_sum;
        r_k1   <= i_k;
        r_k2   <= r_k1;
        r_k3   <= r_k2;
        r_k4   <= r_k3;
        r_k5   <= r_k4;
        r_k6   <= r_k5;
    end

    // squared distance over the lanes
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            w_sum = w_sum + 72'(r_sq5[i]);
        end
    end

    assign w_hit = r_vld[5] && r_ok6 && (r_sum6 < 72'(r_lim6));

    // stage valids and first hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_found <= 1'b0;
            r_hit   <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_ctl.issue};
            if (i_ctl.start) begin
                r_found <= 1'b0;
                r_hit   <= '0;
            end else if (w_hit && !r_found) begin
                r_found <= 1'b1;
                r_hit   <= r_k6;
            end
        end
    end

    assign o_st.busy  = |r_vld;
    assign o_st.found = r_found;
    assign o_hit      = r_hit;

endmodule

`default_nettype wire

// File: src/tscc_back.sv
// Back end: sequencer, bound check, waypoint selection and result register
`default_nettype none
`include "timed_sphere_collision_check_defines.svh"

module tscc_back import tscc_pkg::*; #(
    parameter int MAX_DIMS      = 4,
    parameter int MAX_OBSTACLES = 16,
    parameter int PATH_POINTS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_empty,
    output logic        o_cmd_pop,
    input  logic [30:0] i_agent_r,
    input  logic [2:0]  i_active_dims,
    input  logic [4:0]  i_active_obs,
    input  logic        i_pop,
    output logic        o_empty,
    output t_result     o_res
);

    localparam int LANES = (MAX_DIMS < NUM_POS) ? MAX_DIMS : NUM_POS;
    localparam int OBS_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int PT_W  = $clog2(PATH_POINTS);
    localparam int ROW_W = $clog2(MAX_OBSTACLES * PATH_POINTS);
    localparam int NO_W  = $clog2(MAX_OBSTACLES + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / PATH_POINTS);

    t_bstate          r_state, n_state;
    t_cmd             r_cmd;
    logic [31:0]      r_lo [LANES];
    logic [31:0]      r_hi [LANES];
    logic             r_oob;
    logic [47:0]      r_qp;
    logic [PT_W-1:0]  r_p1, r_p2;
    logic [OBS_W-1:0] r_k;
    logic             r_ov;
    t_result          r_res;
    logic [2:0]       w_nd;
    logic [NO_W-1:0]  w_no;
    logic             w_oob;
    logic [PT_W-1:0]  w_p1, w_p2;
    logic             w_last;
    logic             w_fire;
    logic             w_take;
    t_eval_ctl        w_ctl;
    t_eval_st         w_st;
    logic [OBS_W-1:0] w_hit;

    // effective counts
    assign w_nd = (i_active_dims > 3'(LANES)) ? 3'(LANES) : i_active_dims;
    assign w_no = (32'(i_active_obs) > MAX_OBSTACLES) ? NO_W'(MAX_OBSTACLES)
                                                       : NO_W'(i_active_obs);
    assign w_last = (32'(r_k) + 32'd1) == 32'(w_no);
    assign w_take = !r_ov || i_pop;
    assign w_fire = (r_state == BS_DONE) && w_take;

    // bounds shrunk by the agent radius
    always_comb begin
        logic signed [33:0] v_lo;
        logic signed [33:0] v_hi;
        logic signed [33:0] v_p;
        logic signed [33:0] v_r;
        w_oob = 1'b0;
        v_r   = 34'($signed({1'b0, i_agent_r}));
        for (int d = 0; d < LANES; d++) begin
            v_lo = 34'($signed(r_lo[d])) + v_r;
            v_hi = 34'($signed(r_hi[d])) - v_r;
            v_p  = 34'($signed(r_cmd.pos[d]));
            if ((3'(d) < w_nd) && ((v_p < v_lo) || (v_p > v_hi))) begin
                w_oob = 1'b1;
            end
        end
    end

    // waypoint slots: integer time modulo path length via reciprocal
    always_comb begin
        logic [15:0] v_q;
        logic [31:0] v_rem;
        v_q   = r_qp[47:32];
        v_rem = 32'(r_cmd.time_value[31:16]) - 32'(v_q) * PATH_POINTS;
        if (v_rem >= PATH_POINTS) begin
            v_rem = v_rem - PATH_POINTS;
        end
        w_p1 = PT_W'(v_rem);
        w_p2 = ((32'(w_p1) + 32'd1) == PATH_POINTS) ? '0 : PT_W'(32'(w_p1) + 32'd1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty && (i_cmd.op == OP_QUERY)) begin
                    n_state = BS_BOUND;
                end
            end
            BS_BOUND: n_state = BS_MOD;
            BS_MOD: begin
                if (r_oob || (w_no == '0)) begin
                    n_state = BS_DONE;
                end else begin
                    n_state = BS_ISSUE;
                end
            end
            BS_ISSUE: begin
                if (w_last) begin
                    n_state = BS_DRAIN;
                end
            end
            BS_DRAIN: begin
                if (!w_st.busy) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (w_take) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_pop   = (r_state == BS_IDLE) && !i_cmd_empty;
        w_ctl.start = r_state == BS_BOUND;
        w_ctl.issue = r_state == BS_ISSUE;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_pop) begin
                r_ov <= 1'b0;
            end
            if (w_fire) begin
                r_ov <= 1'b1;
            end
        end
    end

    // query payload, bounds and result
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            for (int d = 0; d < LANES; d++) begin
                if (32'(i_cmd.dim) == d) begin
                    if (i_cmd.op == OP_WR_LO) begin
                        r_lo[d] <= i_cmd.value;
                    end
                    if (i_cmd.op == OP_WR_HI) begin
                        r_hi[d] <= i_cmd.value;
                    end
                end
            end
        end
        if (r_state == BS_BOUND) begin
            r_oob <= w_oob;
            r_qp  <= 48'(r_cmd.time_value[31:16]) * 48'(RECIP);
        end
        if (r_state == BS_MOD) begin
            r_p1 <= w_p1;
            r_p2 <= w_p2;
            r_k  <= '0;
        end
        if (r_state == BS_ISSUE) begin
            r_k <= r_k + 1'b1;
        end
        if (w_fire) begin
            r_res.state_valid   <= !r_oob && !w_st.found;
            r_res.out_of_bounds <= r_oob;
            r_res.collided      <= !r_oob && w_st.found;
            r_res.hit_obstacle  <= (!r_oob && w_st.found) ? 4'(w_hit) : 4'd0;
        end
    end

    tscc_eval #(
        .MAX_DIMS      (MAX_DIMS),
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .PATH_POINTS   (PATH_POINTS)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_k        (r_k),
        .i_p1       (r_p1),
        .i_p2       (r_p2),
        .i_frac     (r_cmd.time_value[15:0]),
        .i_pos      (r_cmd.pos),
        .i_nd       (w_nd),
        .i_agent_r  (i_agent_r),
        .i_wp_we    (o_cmd_pop && (i_cmd.op == OP_WR_WP)),
        .i_wp_row   (ROW_W'(32'(i_cmd.obs) * PATH_POINTS + 32'(i_cmd.pt))),
        .i_wp_lane  (i_cmd.dim),
        .i_rad_we   (o_cmd_pop && (i_cmd.op == OP_WR_RAD)),
        .i_rad_addr (OBS_W'(i_cmd.obs)),
        .i_wdata    (i_cmd.value),
        .o_st       (w_st),
        .o_hit      (w_hit)
    );

    assign o_empty = !r_ov;
    assign o_res   = r_res;

    // checks
    `TSCC_ASSERT_IMPL(a_issue_in_range, i_clk, i_rst_n, r_state == BS_ISSUE, 32'(r_k) < 32'(w_no))
    `TSCC_ASSERT_NEXT(a_bound_then_mod, i_clk, i_rst_n, r_state == BS_BOUND, r_state == BS_MOD)
    `TSCC_ASSERT_NEXT(a_drain_done, i_clk, i_rst_n, (r_state == BS_DRAIN) && !w_st.busy, r_state == BS_DONE)
    `TSCC_ASSERT_ALWAYS(a_one_outcome, i_clk, i_rst_n, !r_ov || $onehot({r_res.state_valid, r_res.out_of_bounds, r_res.collided}))

endmodule

`default_nettype wire

// File: src/timed_sphere_collision_check.sv
// Top level of the timed sphere collision check: queue ports, registers, front and back ends
// A query runs bound check and slot selection, issues the active obstacles and drains;
// an out-of-bounds query, or one with no active obstacles, skips issue; one obstacle a cycle.
// The per-obstacle rate is set by the dual-read waypoint memory, two rows per obstacle.
// Synchronous active-low reset clears queues, sequencer and registers; stores are unwritten.
`default_nettype none

module timed_sphere_collision_check import tscc_pkg::*; #(
    parameter int MAX_DIMS      = 4,
    parameter int MAX_OBSTACLES = 16,
    parameter int PATH_POINTS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_obstacle_index,
    input  logic [2:0]  i_point_index,
    input  logic [1:0]  i_dim_index,
    input  logic [31:0] i_write_value,
    input  logic [31:0] i_pos_0,
    input  logic [31:0] i_pos_1,
    input  logic [31:0] i_pos_2,
    input  logic [31:0] i_pos_3,
    input  logic [31:0] i_time_value,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_state_valid,
    output logic        o_out_of_bounds,
    output logic        o_collided,
    output logic [3:0]  o_hit_obstacle,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [30:0]              r_agent_r;
    logic [2:0]               r_active_dims;
    logic [4:0]               r_active_obs;
    logic                     w_cfg_we;
    logic [NUM_POS-1:0][31:0] w_pos;
    t_cmd                     w_front_cmd;
    t_cmd                     w_head_cmd;
    logic                     w_q_push;
    logic                     w_q_full;
    logic                     w_q_pop;
    logic                     w_q_empty;
    t_result                  w_res;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agent_r     <= RST_AGENT_RADIUS;
            r_active_dims <= RST_ACTIVE_DIMS;
            r_active_obs  <= RST_ACTIVE_OBSTACLES;
        end else if (w_cfg_we) begin
            unique case (paddr[3:2])
                CFG_AGENT_RADIUS:     r_agent_r     <= pwdata[30:0];
                CFG_ACTIVE_DIMS:      r_active_dims <= pwdata[2:0];
                CFG_ACTIVE_OBSTACLES: r_active_obs  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (paddr[3:2])
            CFG_AGENT_RADIUS:     prdata = 32'(r_agent_r);
            CFG_ACTIVE_DIMS:      prdata = 32'(r_active_dims);
            CFG_ACTIVE_OBSTACLES: prdata = 32'(r_active_obs);
            default:              prdata = '0;
        endcase
    end

    assign w_pos = {i_pos_3, i_pos_2, i_pos_1, i_pos_0};

    tscc_front #(
        .MAX_DIMS      (MAX_DIMS),
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .PATH_POINTS   (PATH_POINTS)
    ) u_front (
        .i_push           (i_push),
        .o_full           (o_full),
        .i_req_type       (i_req_type),
        .i_obstacle_index (i_obstacle_index),
        .i_point_index    (i_point_index),
        .i_dim_index      (i_dim_index),
        .i_write_value    (i_write_value),
        .i_pos            (w_pos),
        .i_time_value     (i_time_value),
        .i_q_full         (w_q_full),
        .o_q_push         (w_q_push),
        .o_cmd            (w_front_cmd)
    );

    tscc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_cmd   (w_head_cmd)
    );

    tscc_back #(
        .MAX_DIMS      (MAX_DIMS),
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .PATH_POINTS   (PATH_POINTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head_cmd),
        .i_cmd_empty   (w_q_empty),
        .o_cmd_pop     (w_q_pop),
        .i_agent_r     (r_agent_r),
        .i_active_dims (r_active_dims),
        .i_active_obs  (r_active_obs),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_res         (w_res)
    );

    assign o_state_valid   = w_res.state_valid;
    assign o_out_of_bounds = w_res.out_of_bounds;
    assign o_collided      = w_res.collided;
    assign o_hit_obstacle  = w_res.hit_obstacle;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the timed sphere collision check block
`default_nettype none

module testbench import tscc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;

    // one input item as it is driven on the ports
    typedef struct packed {
        logic [2:0]       req;
        logic [3:0]       obs;
        logic [2:0]       pt;
        logic [1:0]       dim;
        logic [31:0]      wval;
        logic [3:0][31:0] pos;
        logic [31:0]      tval;
    } t_probe;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [2:0]  i_req_type = '0;
    logic [3:0]  i_obstacle_index = '0;
    logic [2:0]  i_point_index = '0;
    logic [1:0]  i_dim_index = '0;
    logic [31:0] i_write_value = '0;
    logic [31:0] i_pos_0 = '0;
    logic [31:0] i_pos_1 = '0;
    logic [31:0] i_pos_2 = '0;
    logic [31:0] i_pos_3 = '0;
    logic [31:0] i_time_value = '0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic        o_state_valid;
    logic        o_out_of_bounds;
    logic        o_collided;
    logic [3:0]  o_hit_obstacle;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    timed_sphere_collision_check dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_req_type(i_req_type), .i_obstacle_index(i_obstacle_index),
        .i_point_index(i_point_index), .i_dim_index(i_dim_index),
        .i_write_value(i_write_value), .i_pos_0(i_pos_0), .i_pos_1(i_pos_1),
        .i_pos_2(i_pos_2), .i_pos_3(i_pos_3), .i_time_value(i_time_value),
        .o_empty(o_empty), .i_pop(i_pop), .o_state_valid(o_state_valid),
        .o_out_of_bounds(o_out_of_bounds), .o_collided(o_collided),
        .o_hit_obstacle(o_hit_obstacle), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the block's stores and registers
    int          waypoint_q [512];
    int          radius_q [16];
    int          lower_q [4];
    int          upper_q [4];
    bit          waypoint_set [512];
    bit          radius_set [16];
    bit          lower_set [4];
    bit          upper_set [4];
    logic [30:0] agent_radius_r;
    logic [2:0]  dims_r;
    logic [4:0]  obstacles_r;

    t_result verdict_q [$];
    int      fail_count = 0;
    int      items_sent = 0;
    int      queries_sent = 0;
    int      verdicts_seen = 0;
    int      hits_seen = 0;
    int      oob_seen = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    int      quiet_cycles = 0;

    // verdict for one query; flags any read of a store entry never written
    function automatic t_result collision_verdict(input t_probe it, output bit unsafe);
        t_result     res;
        int          nd;
        int          no;
        longint      r;
        longint      lo;
        longint      hi;
        longint      p;
        longint      rs;
        longint      a;
        longint      b;
        longint      c;
        longint      df;
        longint      frac;
        logic [15:0] ip;
        logic [2:0]  p1;
        logic [2:0]  p2;
        logic [63:0] lim;
        logic [63:0] lo_sum;
        logic [63:0] sq;
        logic [63:0] m;
        int          hi_sum;
        int          i1;
        int          i2;
        res = '0;
        unsafe = 1'b0;
        nd = (dims_r > 4) ? 4 : dims_r;
        no = (obstacles_r > 16) ? 16 : obstacles_r;
        r = longint'(agent_radius_r);
        // shrunk bounds
        for (int d = 0; d < nd; d++) begin
            if (!lower_set[d] || !upper_set[d]) unsafe = 1'b1;
            lo = longint'(lower_q[d]) + r;
            hi = longint'(upper_q[d]) - r;
            p = longint'($signed(it.pos[d]));
            if (p < lo || p > hi) begin
                res.out_of_bounds = 1'b1;
                return res;
            end
        end
        ip = it.tval[31:16];
        frac = longint'(it.tval[15:0]);
        p1 = ip[2:0];
        p2 = ip[2:0] + 3'd1;
        // obstacles in index order, first hit wins
        for (int k = 0; k < no; k++) begin
            if (!radius_set[k]) unsafe = 1'b1;
            rs = r + longint'(radius_q[k]);
            if (rs <= 0) continue;
            lim = rs * rs;
            lo_sum = '0;
            hi_sum = 0;
            for (int d = 0; d < nd; d++) begin
                i1 = {k[3:0], p1, d[1:0]};
                i2 = {k[3:0], p2, d[1:0]};
                if (!waypoint_set[i1] || !waypoint_set[i2]) unsafe = 1'b1;
                a = longint'(waypoint_q[i1]);
                b = longint'(waypoint_q[i2]);
                c = a + ((frac * (b - a)) >>> 16);
                df = longint'($signed(it.pos[d])) - c;
                m = (df < 0) ? -df : df;
                sq = m * m;
                lo_sum = lo_sum + sq;
                if (lo_sum < sq) hi_sum++;
            end
            if (hi_sum == 0 && lo_sum < lim) begin
                res.collided = 1'b1;
                res.hit_obstacle = k[3:0];
                return res;
            end
        end
        res.state_valid = 1'b1;
        return res;
    endfunction

    // apply an accepted item to the shadow state, queue the verdict of a query
    task automatic absorb_item(input t_probe it);
        bit      unsafe;
        t_result res;
        case (it.req)
            REQ_WR_WP: begin
                waypoint_q[{it.obs, it.pt, it.dim}] = int'(it.wval);
                waypoint_set[{it.obs, it.pt, it.dim}] = 1'b1;
            end
            REQ_WR_RAD: begin
                radius_q[it.obs] = int'(it.wval);
                radius_set[it.obs] = 1'b1;
            end
            REQ_WR_LO: begin
                lower_q[it.dim] = int'(it.wval);
                lower_set[it.dim] = 1'b1;
            end
            REQ_WR_HI: begin
                upper_q[it.dim] = int'(it.wval);
                upper_set[it.dim] = 1'b1;
            end
            REQ_QUERY: begin
                res = collision_verdict(it, unsafe);
                verdict_q.push_back(res);
                queries_sent++;
            end
            default: ;
        endcase
    endtask

    // push one item; push stays high afterwards until the next item or a lull
    task automatic send_item(input t_probe it);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_req_type <= it.req;
        i_obstacle_index <= it.obs;
        i_point_index <= it.pt;
        i_dim_index <= it.dim;
        i_write_value <= it.wval;
        i_pos_0 <= it.pos[0];
        i_pos_1 <= it.pos[1];
        i_pos_2 <= it.pos[2];
        i_pos_3 <= it.pos[3];
        i_time_value <= it.tval;
        do @(posedge i_clk); while (o_full);
        absorb_item(it);
        if (it.req <= REQ_WR_HI) items_sent++;
    endtask

    // lower push, wait for every verdict, then let the block settle
    task automatic drain;
        i_push <= 1'b0;
        while (verdict_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB register write: setup then access phase
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            CFG_AGENT_RADIUS:     agent_radius_r = val[30:0];
            CFG_ACTIVE_DIMS:      dims_r = val[2:0];
            CFG_ACTIVE_OBSTACLES: obstacles_r = val[4:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_probe make_probe(input logic [2:0] req, input logic [3:0] obs,
                                          input logic [2:0] pt, input logic [1:0] dim,
                                          input logic [31:0] wval);
        t_probe it;
        it = '0;
        it.req = req;
        it.obs = obs;
        it.pt = pt;
        it.dim = dim;
        it.wval = wval;
        return it;
    endfunction

    function automatic t_probe make_query(input logic [31:0] p0, input logic [31:0] p1,
                                          input logic [31:0] tv);
        t_probe it;
        it = make_probe(REQ_QUERY, '0, '0, '0, '0);
        it.pos[0] = p0;
        it.pos[1] = p1;
        it.tval = tv;
        return it;
    endfunction

    function automatic logic [31:0] small_signed(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // random item: mostly well-formed writes and queries near loaded obstacles
    function automatic t_probe random_probe;
        t_probe      it;
        int          kind;
        int          k;
        logic [15:0] ip;
        it.req = 3'($urandom);
        it.obs = 4'($urandom);
        it.pt = 3'($urandom);
        it.dim = 2'($urandom);
        it.wval = $urandom;
        for (int d = 0; d < 4; d++) it.pos[d] = $urandom;
        it.tval = $urandom;
        kind = $urandom_range(99);
        if (kind < 8) begin
            it.req = $urandom_range(0, 1) ? REQ_WR_LO : REQ_WR_HI;
            if ($urandom_range(9) > 0)
                it.wval = (it.req == REQ_WR_LO) ? -$urandom_range(0, 32'h0040_0000)
                                                : $urandom_range(0, 32'h0040_0000);
        end else if (kind < 20) begin
            it.req = REQ_WR_RAD;
            if ($urandom_range(9) > 0) it.wval = $urandom_range(32'h1000, 32'h3_0000);
        end else if (kind < 55) begin
            it.req = REQ_WR_WP;
            if ($urandom_range(9) < 7) it.obs = 4'($urandom_range(0, 3));
            if ($urandom_range(19) > 0) it.wval = small_signed(32'h8_0000);
        end else if (kind < 60) begin
            it.req = 3'($urandom_range(5, 7));
        end else begin
            it.req = REQ_QUERY;
            if ($urandom_range(1)) begin
                ip = 16'($urandom_range(0, 40));
                it.tval[31:16] = ip;
            end
            ip = it.tval[31:16];
            k = $urandom_range(0, 3);
            if ($urandom_range(9) < 8)
                for (int d = 0; d < 4; d++)
                    it.pos[d] = waypoint_q[{k[3:0], ip[2:0], d[1:0]}]
                                + small_signed(32'h2_0000);
        end
        return it;
    endfunction

    // check each result taken from the block against the oldest verdict
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && i_pop && !o_empty) begin
            verdicts_seen++;
            if (o_collided) hits_seen++;
            if (o_out_of_bounds) oob_seen++;
            if (verdict_q.size() == 0) begin
                $display("%0t: result with no query outstanding", $time);
                fail_count++;
            end else begin
                exp_r = verdict_q.pop_front();
                if (o_state_valid !== exp_r.state_valid) begin
                    $display("%0t: state_valid exp %0b got %0b", $time,
                             exp_r.state_valid, o_state_valid);
                    fail_count++;
                end
                if (o_out_of_bounds !== exp_r.out_of_bounds) begin
                    $display("%0t: out_of_bounds exp %0b got %0b", $time,
                             exp_r.out_of_bounds, o_out_of_bounds);
                    fail_count++;
                end
                if (o_collided !== exp_r.collided) begin
                    $display("%0t: collided exp %0b got %0b", $time,
                             exp_r.collided, o_collided);
                    fail_count++;
                end
                if (o_hit_obstacle !== exp_r.hit_obstacle) begin
                    $display("%0t: hit_obstacle exp %0d got %0d", $time,
                             exp_r.hit_obstacle, o_hit_obstacle);
                    fail_count++;
                end
            end
        end
        i_pop <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || (psel && penable) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // bounds at the extremes, out-of-bounds queries, ignored request codes
    task automatic test_bounds;
        for (int d = 0; d < 4; d++) begin
            send_item(make_probe(REQ_WR_LO, '0, '0, d[1:0], 32'h8000_0000));
            send_item(make_probe(REQ_WR_HI, '0, '0, d[1:0], 32'h7fff_ffff));
        end
        send_item(make_query(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
        send_item(make_query(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000));
        send_item(make_probe(REQ_WR_LO, '0, '0, 2'd1, 32'h0000_0000));
        send_item(make_query(32'h0000_0000, 32'hffff_ffff, 32'h0001_8000));
        for (int q = 5; q <= 7; q++)
            send_item(make_probe(q[2:0], 4'hf, 3'h7, 2'h3, 32'hffff_ffff));
        drain();
    endtask

    // one moving obstacle: hit, miss, radius sum not positive, zero dimensions
    task automatic test_collision;
        send_item(make_probe(REQ_WR_LO, '0, '0, 2'd1, 32'h8000_0000));
        send_item(make_probe(REQ_WR_RAD, 4'd0, '0, '0, 32'h0001_0000));
        send_item(make_probe(REQ_WR_WP, 4'd0, 3'd0, 2'd0, 32'h0000_0000));
        send_item(make_probe(REQ_WR_WP, 4'd0, 3'd0, 2'd1, 32'h0000_0000));
        send_item(make_probe(REQ_WR_WP, 4'd0, 3'd1, 2'd0, 32'h0004_0000));
        send_item(make_probe(REQ_WR_WP, 4'd0, 3'd1, 2'd1, 32'h0000_0000));
        drain();
        reg_write(CFG_ACTIVE_OBSTACLES, 32'd1);
        send_item(make_query(32'h0002_0000, 32'h0000_0000, 32'h0000_8000));
        send_item(make_query(32'h0002_0000, 32'h0003_0000, 32'h0000_8000));
        send_item(make_probe(REQ_WR_RAD, 4'd0, '0, '0, 32'hffff_0000));
        send_item(make_query(32'h0002_0000, 32'h0000_0000, 32'h0008_8000));
        drain();
        reg_write(CFG_ACTIVE_DIMS, 32'd0);
        send_item(make_probe(REQ_WR_RAD, 4'd0, '0, '0, 32'h0000_0001));
        send_item(make_query(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678));
        drain();
    endtask

    // random traffic under one register setting and one idling pattern
    task automatic test_random(input int s_pct, input int r_pct, input logic [31:0] rad,
                               input logic [31:0] dims, input logic [31:0] obstacles,
                               input int count);
        t_probe it;
        bit     unsafe;
        t_result res;
        int     target;
        drain();
        reg_write(CFG_AGENT_RADIUS, rad);
        reg_write(CFG_ACTIVE_DIMS, dims);
        reg_write(CFG_ACTIVE_OBSTACLES, obstacles);
        sender_idle_pct = s_pct;
        receiver_stall_pct = r_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            it = random_probe();
            if (it.req == REQ_QUERY) begin
                res = collision_verdict(it, unsafe);
                if (unsafe) continue;
            end
            send_item(it);
            // let everything drain once mid-phase
            if (items_sent == target - count / 2) drain();
        end
        drain();
    endtask

    initial begin
        agent_radius_r = RST_AGENT_RADIUS;
        dims_r = RST_ACTIVE_DIMS;
        obstacles_r = RST_ACTIVE_OBSTACLES;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bounds();
        test_collision();
        test_random(30, 72, 32'd0, 32'd4, 32'd4, 250);
        test_random(72, 30, 32'h7fff_ffff, 32'd7, 32'd31, 100);
        test_random(72, 30, 32'h0000_8000, 32'd3, 32'd16, 200);
        test_random(0, 0, 32'h0000_1234, 32'd1, 32'd2, 300);
        $display("covered %0d items, %0d queries: %0d results, %0d collisions, %0d out of bounds",
                 items_sent, queries_sent, verdicts_seen, hits_seen, oob_seen);
        $display("register settings from reset values to extremes, three idling patterns");
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d verdicts outstanding", fail_count, verdict_q.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
